FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define AST_CHK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AST_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/grc_pkg.sv
`default_nettype none
package grc_pkg;
    localparam int GRID_SIZE    = 64;
    localparam int SCREEN_WIDTH = 1920;
    localparam int FRAC_BITS    = 16;

    localparam int GRID_BITS = $clog2(GRID_SIZE);
    localparam int MAP_AW    = 2 * GRID_BITS;
    localparam int MAP_DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int CW        = GRID_BITS + 2;
    localparam int STEP_CAP  = 2 * GRID_SIZE + 2;
    localparam int CNT_W     = $clog2(STEP_CAP + 1);

    localparam int POS_W  = 22;
    localparam int VEC_W  = 19;
    localparam int COL_W  = 11;
    localparam int CELL_W = 6;
    localparam int DIST_W = 32;
    localparam int CAM_W  = FRAC_BITS + 2;
    localparam int R_W    = VEC_W + 3;

    localparam int DIV_NW = (2 * FRAC_BITS + 1 > FRAC_BITS + COL_W + 1) ?
                            2 * FRAC_BITS + 1 : FRAC_BITS + COL_W + 1;
    localparam int DIV_DW = (R_W > $clog2(SCREEN_WIDTH + 1)) ?
                            R_W : $clog2(SCREEN_WIDTH + 1);
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam int MA_W = (FRAC_BITS + 2 > VEC_W + 1) ? FRAC_BITS + 2 : VEC_W + 1;
    localparam int MB_W = (DIST_W + 2 > CAM_W) ? DIST_W + 2 : CAM_W;
    localparam int MP_W = MA_W + MB_W;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = POS_W;
    localparam logic [CFG_AW-1:0] CFG_POS_X   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_DIR_X   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DIR_Y   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_PLANE_Y = 3'd5;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    localparam int IN_W  = 24;
    localparam int OUT_W = 64;
endpackage
`default_nettype wire

FILE: design/grid_ray_caster_dda.sv
`default_nettype none
// channel  | dir | fields (lowest bit up)
// s_axis   | in  | tuser: kind; tdata: column, cell_x, cell_y, wall
// m_axis   | out | tdata: ray_column, perp_dist, hit_side, hit_x, hit_y, escaped
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// a cell write in range goes to the map when taken; a cast runs its setup on the
// shared bit-serial divider (a zero direction component skips its division),
// then grid steps with a wall map read each, none for the step that leaves the grid,
// up to 2 * GRID_SIZE + 2 steps, and then loads the result
// after reset the wall map is cleared one cell a cycle, all MAP_DEPTH (4096) cells,
// with no item taken; a finished result waits in the output register, and the next
// cast stalls at its end until that beat is taken
module grid_ray_caster_dda (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [grc_pkg::IN_W-1:0]    s_axis_tdata,  // column, cell_x, cell_y, wall
    input  wire logic                        s_axis_tuser,  // kind
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [grc_pkg::OUT_W-1:0]        m_axis_tdata,  // ray_column, perp_dist,
                                                            // hit_side, hit_x, hit_y, escaped
    input  wire logic                        i_cfg_we,
    input  wire logic [grc_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  wire logic [grc_pkg::CFG_DW-1:0]  i_cfg_data
);
    import grc_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_CAM, S_MULX, S_MULY, S_AXDIV, S_AXWAIT, S_AXSIDE, S_STEP, S_CHK, S_OUT
    } t_state;

    t_state                    r_state;
    logic [POS_W-1:0]          r_pos_x, r_pos_y;
    logic signed [VEC_W-1:0]   r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    logic [COL_W-1:0]          r_col;
    logic signed [CAM_W-1:0]   r_cam;
    logic signed [R_W-1:0]     r_rx, r_ry;
    logic                      r_axis;
    logic                      r_xz, r_xn, r_yz, r_yn;
    logic [DIST_W-1:0]         r_dx, r_dy, r_sdx, r_sdy, r_perp;
    logic signed [CW-1:0]      r_mx, r_my;
    logic [GRID_BITS-1:0]      r_lx, r_ly;
    logic                      r_side, r_esc, r_start_out;
    logic [CNT_W-1:0]          r_n;
    logic                      r_ovalid;
    logic [OUT_W-1:0]          r_odata;

    logic                      accept, clearing, map_rdata;
    logic [COL_W-1:0]          in_col;
    logic [CELL_W-1:0]         in_cx, in_cy;
    logic                      in_wall;

    logic                      div_start, div_done;
    logic [DIV_NW-1:0]         div_num, div_quot;
    logic [DIV_DW-1:0]         div_den;

    logic signed [R_W-1:0]     r_cur;
    logic [R_W-1:0]            r_mag;
    logic [FRAC_BITS-1:0]      frac;
    logic [FRAC_BITS:0]        frac_d;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [MP_W-1:0]    prod, prod_sh;
    logic [DIST_W-1:0]         side_sat, delta_sat;

    logic                      take_x;
    logic [DIST_W:0]           sum;
    logic [DIST_W-1:0]         sd, dl, step_perp;
    logic signed [CW-1:0]      nmx, nmy;
    logic                      outside;
    logic                      out_free;

    assign in_col  = s_axis_tdata[COL_W-1:0];
    assign in_cx   = s_axis_tdata[COL_W +: CELL_W];
    assign in_cy   = s_axis_tdata[COL_W+CELL_W +: CELL_W];
    assign in_wall = s_axis_tdata[COL_W+2*CELL_W];

    assign s_axis_tready = (r_state == S_IDLE) && !clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= POS_W'(98304);
            r_pos_y   <= POS_W'(98304);
            r_dir_x   <= VEC_W'(65536);
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= VEC_W'(43253);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POS_X:   r_pos_x   <= i_cfg_data;
                CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                CFG_DIR_X:   r_dir_x   <= i_cfg_data[VEC_W-1:0];
                CFG_DIR_Y:   r_dir_y   <= i_cfg_data[VEC_W-1:0];
                CFG_PLANE_X: r_plane_x <= i_cfg_data[VEC_W-1:0];
                CFG_PLANE_Y: r_plane_y <= i_cfg_data[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    // axis under setup
    assign r_cur  = r_axis ? r_ry : r_rx;
    assign r_mag  = r_cur[R_W-1] ? R_W'(-r_cur) : R_W'(r_cur);
    assign frac   = r_axis ? r_pos_y[FRAC_BITS-1:0] : r_pos_x[FRAC_BITS-1:0];
    assign frac_d = (r_axis ? r_yn : r_xn) ? {1'b0, frac} :
                    (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac};

    // one shared multiplier: camera products, then side distance products
    always_comb begin
        case (r_state)
            S_MULX: begin
                mul_a = MA_W'(r_plane_x);
                mul_b = MB_W'(r_cam);
            end
            S_MULY: begin
                mul_a = MA_W'(r_plane_y);
                mul_b = MB_W'(r_cam);
            end
            default: begin
                mul_a = MA_W'($signed({1'b0, frac_d}));
                mul_b = MB_W'($signed({1'b0, (r_axis ? r_dy : r_dx)}));
            end
        endcase
    end
    assign prod      = MP_W'(mul_a) * MP_W'(mul_b);
    assign prod_sh   = prod >>> FRAC_BITS;
    assign side_sat  = ((prod_sh >>> DIST_W) != '0) ? DIST_MAX : prod_sh[DIST_W-1:0];
    assign delta_sat = ((div_quot >> DIST_W) != '0) ? DIST_MAX : div_quot[DIST_W-1:0];

    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_NW'(1) << (2 * FRAC_BITS);
        div_den   = DIV_DW'(r_mag);
        if (r_state == S_IDLE) begin
            div_start = accept && (s_axis_tuser == KIND_CAST);
            div_num   = DIV_NW'(in_col) << (FRAC_BITS + 1);
            div_den   = DIV_DW'(SCREEN_WIDTH);
        end else if (r_state == S_AXDIV) begin
            div_start = (r_cur != '0);
        end
    end

    grc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // one dda step
    assign take_x    = r_sdx < r_sdy;
    assign sum       = take_x ? {1'b0, r_sdx} + {1'b0, r_dx} : {1'b0, r_sdy} + {1'b0, r_dy};
    assign sd        = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    assign dl        = take_x ? r_dx : r_dy;
    assign step_perp = (sd == DIST_MAX) ? DIST_MAX : sd - dl;
    assign nmx = (take_x && !r_xz) ? (r_xn ? r_mx - CW'(1) : r_mx + CW'(1)) : r_mx;
    assign nmy = (!take_x && !r_yz) ? (r_yn ? r_my - CW'(1) : r_my + CW'(1)) : r_my;
    assign outside = (nmx < 0) || (nmy < 0) ||
                     (nmx > CW'(GRID_SIZE - 1)) || (nmy > CW'(GRID_SIZE - 1));

    grc_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (accept && (s_axis_tuser == KIND_WRITE) &&
                     (32'(in_cx) < GRID_SIZE) && (32'(in_cy) < GRID_SIZE)),
        .i_waddr    ({in_cy[GRID_BITS-1:0], in_cx[GRID_BITS-1:0]}),
        .i_wdata    (in_wall),
        .i_raddr    ({nmy[GRID_BITS-1:0], nmx[GRID_BITS-1:0]}),
        .o_rdata    (map_rdata),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (s_axis_tuser == KIND_CAST)) begin
                        r_col       <= in_col;
                        r_axis      <= 1'b0;
                        r_n         <= '0;
                        r_mx        <= CW'({1'b0, r_pos_x[POS_W-1:FRAC_BITS]});
                        r_my        <= CW'({1'b0, r_pos_y[POS_W-1:FRAC_BITS]});
                        r_lx        <= r_pos_x[FRAC_BITS +: GRID_BITS];
                        r_ly        <= r_pos_y[FRAC_BITS +: GRID_BITS];
                        r_start_out <= (32'(r_pos_x[POS_W-1:FRAC_BITS]) >= GRID_SIZE) ||
                                       (32'(r_pos_y[POS_W-1:FRAC_BITS]) >= GRID_SIZE);
                        r_state     <= S_CAM;
                    end
                end
                S_CAM: begin
                    if (div_done) begin
                        r_cam   <= CAM_W'(div_quot) - CAM_W'(1 << FRAC_BITS);
                        r_state <= S_MULX;
                    end
                end
                S_MULX: begin
                    r_rx    <= R_W'(r_dir_x) + R_W'(prod_sh);
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_ry    <= R_W'(r_dir_y) + R_W'(prod_sh);
                    r_state <= S_AXDIV;
                end
                S_AXDIV: begin
                    if (r_cur == '0) begin
                        if (r_axis) begin
                            r_yz <= 1'b1; r_yn <= 1'b0; r_dy <= DIST_MAX; r_sdy <= DIST_MAX;
                            r_state <= S_STEP;
                        end else begin
                            r_xz <= 1'b1; r_xn <= 1'b0; r_dx <= DIST_MAX; r_sdx <= DIST_MAX;
                            r_axis <= 1'b1;
                        end
                    end else begin
                        if (r_axis) begin
                            r_yz <= 1'b0; r_yn <= r_cur[R_W-1];
                        end else begin
                            r_xz <= 1'b0; r_xn <= r_cur[R_W-1];
                        end
                        r_state <= S_AXWAIT;
                    end
                end
                S_AXWAIT: begin
                    if (div_done) begin
                        if (r_axis) begin
                            r_dy <= delta_sat;
                        end else begin
                            r_dx <= delta_sat;
                        end
                        r_state <= S_AXSIDE;
                    end
                end
                S_AXSIDE: begin
                    if (r_axis) begin
                        r_sdy   <= side_sat;
                        r_state <= S_STEP;
                    end else begin
                        r_sdx   <= side_sat;
                        r_axis  <= 1'b1;
                        r_state <= S_AXDIV;
                    end
                end
                S_STEP: begin
                    if (r_start_out) begin
                        r_perp  <= '0;
                        r_side  <= 1'b0;
                        r_esc   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_lx   <= r_mx[GRID_BITS-1:0];
                        r_ly   <= r_my[GRID_BITS-1:0];
                        r_mx   <= nmx;
                        r_my   <= nmy;
                        r_side <= !take_x;
                        r_perp <= step_perp;
                        if (take_x) begin
                            r_sdx <= sd;
                        end else begin
                            r_sdy <= sd;
                        end
                        if (outside) begin
                            r_esc   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_lx <= r_mx[GRID_BITS-1:0];
                    r_ly <= r_my[GRID_BITS-1:0];
                    if (map_rdata) begin
                        r_esc   <= 1'b0;
                        r_state <= S_OUT;
                    end else if (r_n == CNT_W'(STEP_CAP - 1)) begin
                        // no progress: ray never leaves its cell
                        r_esc   <= 1'b1;
                        r_perp  <= DIST_MAX;
                        r_state <= S_OUT;
                    end else begin
                        r_n     <= r_n + CNT_W'(1);
                        r_state <= S_STEP;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= OUT_W'({r_esc, CELL_W'(r_ly), CELL_W'(r_lx),
                                            r_side, r_perp, r_col});
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `AST_CHK(a_no_take_clearing, clearing |-> !s_axis_tready, "item taken during map clear")
    `AST_CHK(a_step_cap, (r_state == S_CHK) |-> (r_n < CNT_W'(STEP_CAP)), "step count past cap")
    `AST_CHK(a_out_load, (r_state == S_OUT && out_free) |=> (m_axis_tvalid && r_state == S_IDLE), "result not loaded")
    `AST_ANY(a_rst_clear, !i_rst_n |=> (r_state == S_IDLE && !m_axis_tvalid), "reset left a pending result")
endmodule
`default_nettype wire

FILE: design/grc_div.sv
`default_nettype none
module grc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [grc_pkg::DIV_NW-1:0] i_num,
    input  wire logic [grc_pkg::DIV_DW-1:0] i_den,
    output logic                            o_done,
    output logic [grc_pkg::DIV_NW-1:0]      o_quot
);
    import grc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_num[DIV_NW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_NW-2:0], 1'b0};
            r_rem  <= fits ? DIV_DW'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DW-1:0];
            r_quot <= {r_quot[DIV_NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

FILE: design/grc_map.sv
`default_nettype none
module grc_map (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_we,
    input  wire logic [grc_pkg::MAP_AW-1:0] i_waddr,
    input  wire logic                       i_wdata,
    input  wire logic [grc_pkg::MAP_AW-1:0] i_raddr,
    output logic                            o_rdata,
    output logic                            o_clearing
);
    import grc_pkg::*;

    logic              r_mem [MAP_DEPTH];
    logic              r_clr;
    logic [MAP_AW-1:0] r_clr_addr;
    logic              r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + MAP_AW'(1);
            if (r_clr_addr == {MAP_AW{1'b1}}) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr;
endmodule
`default_nettype wire
